>>> rtl/core/crc16fc_pkg.sv
// package for the crc16 frame checker core
// holds item types, command struct, status codes and the crc byte update
// no dependencies
package crc16fc_pkg;

    localparam int unsigned MaxPayload = 64;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);

    localparam logic [7:0]  StartMark = 8'hAA;
    localparam logic [15:0] CrcInit   = 16'hFFFF;
    localparam logic [15:0] CrcPoly   = 16'hA001;
    localparam logic [7:0]  MinFrame  = 8'd5;
    localparam logic [7:0]  PosMax    = 8'd255;
    localparam logic [7:0]  MaxLen    = 8'(MaxPayload);

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_TOO_BIG   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_CRC_BAD   = 3'd4;
    localparam logic [2:0] ST_BAD_START = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [7:0] message_type;
        logic [7:0] frame_len;
        logic [2:0] status;
    } t_out_item;

    // what the back end does with a byte
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CRC,
        OP_RX_HI,
        OP_RX_LO
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       emit;
        logic       last;
        logic [7:0] data;
        logic [7:0] hdr_type;
        logic [7:0] hdr_len;
        logic [2:0] pre_status;
        logic       bad_start;
    } t_cmd;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crc16fc_front.sv
// front end: tracks frame position and header, classifies each byte
// depends on crc16fc_pkg
module crc16fc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  crc16fc_pkg::t_in_item  i_item,
    output logic                   o_cmd_push,
    output crc16fc_pkg::t_cmd      o_cmd
);
    import crc16fc_pkg::*;

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_first, n_first;
    logic [7:0] r_type, n_type;
    logic [7:0] r_len, n_len;

    logic [8:0] len_p3;
    logic [8:0] len_p4;
    logic [8:0] next_len_p5;
    logic       in_payload;
    logic [7:0] count;
    t_op        op;

    // classify the byte against the current position
    always_comb begin
        len_p3      = {1'b0, r_len} + 9'd3;
        len_p4      = {1'b0, r_len} + 9'd4;
        n_pos       = r_pos;
        n_first     = r_first;
        n_type      = r_type;
        n_len       = r_len;
        op          = OP_NONE;
        in_payload  = 1'b0;
        if (r_pos != PosMax) begin
            n_pos = r_pos + 8'd1;
            if (r_pos == 8'd0) begin
                n_first = i_item.data_byte;
                op      = OP_CRC;
            end else if (r_pos == 8'd1) begin
                n_type = i_item.data_byte;
                op     = OP_CRC;
            end else if (r_pos == 8'd2) begin
                n_len = i_item.data_byte;
                op    = OP_CRC;
            end else if ({1'b0, r_pos} < len_p3) begin
                op         = OP_CRC;
                in_payload = 1'b1;
            end else if ({1'b0, r_pos} == len_p3) begin
                op = OP_RX_HI;
            end else if ({1'b0, r_pos} == len_p4) begin
                op = OP_RX_LO;
            end
        end
        count       = n_pos;
        next_len_p5 = {1'b0, n_len} + 9'(MinFrame);
    end

    // command for the back end, with the checks that need no crc
    always_comb begin
        o_cmd.op         = op;
        o_cmd.emit       = in_payload && !i_item.end_of_frame && (r_len <= MaxLen);
        o_cmd.last       = i_item.end_of_frame;
        o_cmd.data       = i_item.data_byte;
        o_cmd.hdr_type   = n_type;
        o_cmd.hdr_len    = n_len;
        o_cmd.bad_start  = (n_first != StartMark);
        if (count < MinFrame) begin
            o_cmd.pre_status = ST_SHORT;
        end else if (n_len > MaxLen) begin
            o_cmd.pre_status = ST_TOO_BIG;
        end else if ({1'b0, count} < next_len_p5) begin
            o_cmd.pre_status = ST_TRUNCATED;
        end else begin
            o_cmd.pre_status = ST_OK;
        end
        o_cmd_push = i_accept && ((op != OP_NONE) || i_item.end_of_frame);
    end

    // frame state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_first <= '0;
            r_type  <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            if (i_item.end_of_frame) begin
                r_pos   <= '0;
                r_first <= '0;
                r_type  <= '0;
                r_len   <= '0;
            end else begin
                r_pos   <= n_pos;
                r_first <= n_first;
                r_type  <= n_type;
                r_len   <= n_len;
            end
        end
    end

endmodule

>>> rtl/core/crc16fc_queue.sv
// short command queue between front and back ends
// depends on crc16fc_pkg
module crc16fc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crc16fc_pkg::t_cmd  i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output crc16fc_pkg::t_cmd  o_cmd
);
    import crc16fc_pkg::*;

    t_cmd                r_mem [QueueDepth];
    logic [QueueAw-1:0]  r_wr_ptr;
    logic [QueueAw-1:0]  r_rd_ptr;
    logic [QueueAw:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QueueAw+1)'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/crc16fc_back.sv
// back end: runs the crc, captures the received crc, forms result items
// depends on crc16fc_pkg
module crc16fc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  crc16fc_pkg::t_cmd       i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_empty,
    input  logic                    i_pop,
    output crc16fc_pkg::t_out_item  o_result
);
    import crc16fc_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx, n_rx;
    logic        r_valid;
    t_out_item   r_result, n_result;
    logic        out_taken;
    logic        gives_result;
    logic        take;

    assign o_empty      = !r_valid;
    assign o_result     = r_result;
    assign out_taken    = i_pop && r_valid;
    assign gives_result = i_cmd.emit || i_cmd.last;
    assign take         = i_cmd_valid && (!gives_result || !r_valid || out_taken);
    assign o_cmd_pop    = take;

    // apply the byte, then form the result
    always_comb begin
        n_crc = r_crc;
        n_rx  = r_rx;
        case (i_cmd.op)
            OP_CRC:   n_crc = crc_byte(r_crc, i_cmd.data);
            OP_RX_HI: n_rx  = {i_cmd.data, r_rx[7:0]};
            OP_RX_LO: n_rx  = {r_rx[15:8], i_cmd.data};
            default:  ;
        endcase
        n_result.is_status    = i_cmd.last;
        n_result.payload_byte = i_cmd.last ? 8'h00 : i_cmd.data;
        n_result.message_type = i_cmd.hdr_type;
        n_result.frame_len    = i_cmd.hdr_len;
        if (!i_cmd.last) begin
            n_result.status = ST_OK;
        end else if (i_cmd.pre_status != ST_OK) begin
            n_result.status = i_cmd.pre_status;
        end else if (n_crc != n_rx) begin
            n_result.status = ST_CRC_BAD;
        end else if (i_cmd.bad_start) begin
            n_result.status = ST_BAD_START;
        end else begin
            n_result.status = ST_OK;
        end
    end

    // crc state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CrcInit;
            r_rx    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_cmd.last) begin
                    r_crc <= CrcInit;
                    r_rx  <= '0;
                end else begin
                    r_crc <= n_crc;
                    r_rx  <= n_rx;
                end
            end
            if (take && gives_result) begin
                r_valid <= 1'b1;
            end else if (out_taken) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && gives_result) begin
            r_result <= n_result;
        end
    end

endmodule

>>> rtl/core/crc16_frame_checker_core.sv
// top level of the crc16 frame checker
// depends on crc16fc_pkg, crc16fc_front, crc16fc_queue, crc16fc_back
//
// Usage:
//   Input channel: one frame byte per transaction (push while full is low),
//   end_of_frame marks the last byte of a frame buffer.
//   Result channel: a queue-like port; while empty is low the oldest result
//   is on o_result, and pop takes it. Payload bytes come out one result each
//   as they arrive; the last byte of a frame gives one status result with
//   type, length and status (ok, too short, too big, truncated, crc mismatch,
//   bad start).
//   The front writes each command into the command queue, then the back end
//   registers the result that appears on o_result.
//   Throughput: one byte per cycle while full is low; the crc byte update is
//   combinational in the back end, and the four-entry command queue lets the
//   front keep accepting while a result waits.
//   Reset (synchronous, active low) empties the queue and output register
//   and starts a new frame. When the receiver stalls, the queue fills and
//   full rises after four commands are held; bytes that give no work (after
//   the crc) do not occupy queue entries.
module crc16_frame_checker_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  crc16fc_pkg::t_in_item   i_item,
    output logic                    empty,
    input  logic                    pop,
    output crc16fc_pkg::t_out_item  o_result
);
    import crc16fc_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    assign accept = push && !full;

    // byte classification
    crc16fc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    // decoupling queue
    crc16fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // crc and result formation
    crc16fc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

>>> tb/crc16fc_frame_check.sv
// frame checker for the crc16 frame checker core testbench
// holds a small crc helper package and the checker that predicts and compares results
// depends on crc16fc_pkg
package crc16fc_tb_util;

    // crc-16/modbus update, one data bit at a time, lsb first
    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ data[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ crc16fc_pkg::CrcPoly;
            end
        end
        return r;
    endfunction

endpackage

module crc16fc_frame_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_full,
    input  crc16fc_pkg::t_in_item  i_item,
    input  logic                   i_empty,
    input  logic                   i_pop,
    input  crc16fc_pkg::t_out_item i_result,
    output int unsigned            o_fail_count,
    output int unsigned            o_pending,
    output int unsigned            o_payload_seen,
    output int unsigned            o_status_seen,
    output logic [5:0]             o_status_mask
);
    timeunit 1ns;
    timeprecision 1ps;

    import crc16fc_pkg::*;
    import crc16fc_tb_util::*;

    // predicted frame state
    logic [7:0]  pos_count;
    logic [15:0] crc_acc;
    logic [7:0]  start_seen;
    logic [7:0]  type_seen;
    logic [7:0]  len_seen;
    logic [15:0] crc_rx;

    t_out_item expected_q[$];

    task automatic clear_frame();
        pos_count  = '0;
        crc_acc    = CrcInit;
        start_seen = '0;
        type_seen  = '0;
        len_seen   = '0;
        crc_rx     = '0;
    endtask

    // advance the frame state by one byte and queue what it should produce
    task automatic track_frame_byte(input t_in_item it);
        t_out_item   exp;
        int unsigned at;
        int unsigned len_now;
        int unsigned count;
        logic        payload_hit;
        at          = 32'(pos_count);
        len_now     = 32'(len_seen);
        payload_hit = 1'b0;
        if (pos_count != PosMax) begin
            if (at == 0) begin
                start_seen = it.data_byte;
                crc_acc    = crc16_update(crc_acc, it.data_byte);
            end else if (at == 1) begin
                type_seen = it.data_byte;
                crc_acc   = crc16_update(crc_acc, it.data_byte);
            end else if (at == 2) begin
                len_seen = it.data_byte;
                crc_acc  = crc16_update(crc_acc, it.data_byte);
            end else if (at < len_now + 3) begin
                crc_acc     = crc16_update(crc_acc, it.data_byte);
                payload_hit = 1'b1;
            end else if (at == len_now + 3) begin
                crc_rx[15:8] = it.data_byte;
            end else if (at == len_now + 4) begin
                crc_rx[7:0] = it.data_byte;
            end
            pos_count = pos_count + 8'd1;
        end

        exp              = '0;
        exp.message_type = type_seen;
        exp.frame_len    = len_seen;
        if (!it.end_of_frame) begin
            // payload passes out only when the declared length is legal
            if (payload_hit && len_now <= MaxPayload) begin
                exp.payload_byte = it.data_byte;
                expected_q.push_back(exp);
            end
        end else begin
            count         = 32'(pos_count);
            exp.is_status = 1'b1;
            if (count < MinFrame) begin
                exp.status = ST_SHORT;
            end else if (len_seen > MaxLen) begin
                exp.status = ST_TOO_BIG;
            end else if (count < 32'(len_seen) + 32'(MinFrame)) begin
                exp.status = ST_TRUNCATED;
            end else if (crc_acc != crc_rx) begin
                exp.status = ST_CRC_BAD;
            end else if (start_seen != StartMark) begin
                exp.status = ST_BAD_START;
            end else begin
                exp.status = ST_OK;
            end
            expected_q.push_back(exp);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // compare one result transaction with the oldest expectation
    task automatic match_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            o_fail_count++;
            $display("%0t unexpected result: expected none, actual 0x%0h",
                     $time, got);
        end else begin
            want = expected_q.pop_front();
            check_field("is_status", 32'(want.is_status), 32'(got.is_status));
            check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            check_field("message_type", 32'(want.message_type), 32'(got.message_type));
            check_field("frame_len", 32'(want.frame_len), 32'(got.frame_len));
            check_field("status", 32'(want.status), 32'(got.status));
            if (want.is_status) begin
                o_status_seen++;
                o_status_mask[want.status] = 1'b1;
            end else begin
                o_payload_seen++;
            end
        end
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            expected_q.delete();
            o_status_mask = '0;
        end else begin
            if (i_pop && !i_empty) begin
                match_result(i_result);
            end
            if (i_push && !i_full) begin
                track_frame_byte(i_item);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

>>> tb/tb_top.sv
// testbench top for crc16_frame_checker_core
// drives frame bytes and result pops, gives the verdict
// depends on crc16fc_pkg and crc16fc_frame_check (with its crc helper package)
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc16fc_pkg::*;
    import crc16fc_tb_util::*;

    localparam int unsigned ResetCycles = 9;
    localparam int unsigned ItemTarget  = 950;
    localparam int unsigned QuietLimit  = 2000;
    localparam int unsigned HoldCycles  = 60;
    localparam int unsigned DrainTail   = 20;

    typedef enum int {
        FK_GOOD,
        FK_TRAILER,
        FK_BAD_CRC,
        FK_BAD_START,
        FK_TRUNC,
        FK_TOO_BIG,
        FK_NOISE,
        FK_LONG
    } t_frame_kind;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned payload_seen;
    int unsigned status_seen;
    logic [5:0]  status_mask;

    logic [7:0]  frame_bytes[$];
    int unsigned bytes_sent;
    int unsigned frame_count;
    bit          sender_burst;
    int unsigned quiet_cycles;

    crc16_frame_checker_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    crc16fc_frame_check u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_item         (i_item),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_payload_seen (payload_seen),
        .o_status_seen  (status_seen),
        .o_status_mask  (status_mask)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QuietLimit);
        $display("%0t no transaction for %0d cycles", $time, QuietLimit);
        $display("CHECK FAILED");
        $finish;
    end

    // header plus npay random payload bytes, no crc yet
    function automatic void make_frame(input logic [7:0] start, input logic [7:0] typ,
                                       input logic [7:0] len, input int unsigned npay);
        frame_bytes.delete();
        frame_bytes.push_back(start);
        frame_bytes.push_back(typ);
        frame_bytes.push_back(len);
        repeat (npay) frame_bytes.push_back(8'($urandom));
    endfunction

    // append crc, high byte first
    function automatic void seal_frame();
        logic [15:0] c;
        c = CrcInit;
        foreach (frame_bytes[k]) c = crc16_update(c, frame_bytes[k]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endfunction

    function automatic void trim_to(input int unsigned n);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    endfunction

    function automatic void add_trailer(input int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    // mostly short payloads, sometimes the maximum
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 8);
        end else if (r < 90) begin
            return $urandom_range(9, MaxPayload - 1);
        end
        return MaxPayload;
    endfunction

    function automatic void build_frame(input t_frame_kind kind);
        int unsigned len;
        int unsigned idx;
        logic [7:0]  start;
        len = pick_len();
        case (kind)
            FK_NOISE: begin
                make_frame(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 7));
                trim_to($urandom_range(1, frame_bytes.size()));
            end
            FK_TOO_BIG: begin
                len = ($urandom_range(0, 3) == 0) ? MaxPayload + 1
                                                  : $urandom_range(MaxPayload + 1, 255);
                make_frame(StartMark, 8'($urandom), 8'(len), $urandom_range(1, 8));
                if ($urandom_range(0, 1) == 1) begin
                    seal_frame();
                end
            end
            FK_BAD_START: begin
                start = 8'($urandom);
                if (start == StartMark) begin
                    start = ~StartMark;
                end
                make_frame(start, 8'($urandom), 8'(len), len);
                seal_frame();
            end
            FK_LONG: begin
                // valid frame followed by enough bytes to saturate the position count
                make_frame(StartMark, 8'($urandom), MaxLen, MaxPayload);
                seal_frame();
                add_trailer($urandom_range(190, 240));
            end
            default: begin
                make_frame(StartMark, 8'($urandom), 8'(len), len);
                seal_frame();
                if (kind == FK_TRAILER) begin
                    add_trailer($urandom_range(1, 6));
                end else if (kind == FK_BAD_CRC) begin
                    idx = frame_bytes.size() - 1 - $urandom_range(0, 1);
                    frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
                end else if (kind == FK_TRUNC) begin
                    trim_to($urandom_range(1, frame_bytes.size() - 1));
                end
            end
        endcase
    endfunction

    // offer one byte, with an optional gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item    nxt;
        int unsigned gap;
        bit          taken;
        if (!sender_burst && $urandom_range(0, 99) < 35) begin
            gap  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        nxt.data_byte    = b;
        nxt.end_of_frame = last;
        push   <= 1'b1;
        i_item <= nxt;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        bytes_sent += frame_bytes.size();
        frame_count++;
    endtask

    // sender waits until every expected result has been taken
    task automatic wait_results_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // result side: random pop stretches plus two long hold-offs
    initial begin
        int unsigned left;
        int unsigned mode;
        int unsigned hold_left;
        int unsigned holds_done;
        bit          want;
        left       = 0;
        mode       = 0;
        hold_left  = 0;
        holds_done = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ((holds_done == 0 && payload_seen + status_seen >= 120) ||
                (holds_done == 1 && payload_seen + status_seen >= 520)) begin
                hold_left = HoldCycles;
                holds_done++;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 9);
                left = (mode == 9) ? $urandom_range(10, 40) : $urandom_range(10, 60);
            end
            left--;
            if (hold_left > 0) begin
                hold_left--;
                want = 1'b0;
            end else if (mode < 4) begin
                want = 1'b1;
            end else if (mode < 7) begin
                want = ($urandom_range(0, 1) == 1);
            end else if (mode < 9) begin
                want = ($urandom_range(0, 3) == 0);
            end else begin
                want = 1'b0;
            end
            @(posedge i_clk);
            pop <= want;
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned pick;
        t_frame_kind kind;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_item      <= '0;
        i_rst_n     <= 1'b0;
        bytes_sent   = 0;
        frame_count  = 0;
        sender_burst = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: too short, single byte
        make_frame(8'hFF, 8'h00, 8'h00, 0);
        trim_to(1);
        send_frame();
        // good frame, empty payload
        make_frame(StartMark, 8'h00, 8'h00, 0);
        seal_frame();
        send_frame();
        // bad start with a byte after the crc
        make_frame(8'h00, 8'hFF, 8'h00, 0);
        seal_frame();
        add_trailer(1);
        send_frame();
        // length at the top of the range
        make_frame(StartMark, 8'h5A, 8'hFF, 2);
        send_frame();
        // frame ends inside the payload
        make_frame(StartMark, 8'h3C, 8'h03, 2);
        send_frame();
        // payload byte extremes with a corrupted crc
        make_frame(StartMark, 8'hC3, 8'h02, 0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        seal_frame();
        frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h01;
        send_frame();

        // random frames, mostly well formed
        while (bytes_sent < ItemTarget) begin
            pick = $urandom_range(0, 99);
            if (frame_count == 12 || pick == 0) begin
                kind = FK_LONG;
            end else if (pick < 45) begin
                kind = FK_GOOD;
            end else if (pick < 55) begin
                kind = FK_TRAILER;
            end else if (pick < 65) begin
                kind = FK_BAD_CRC;
            end else if (pick < 73) begin
                kind = FK_BAD_START;
            end else if (pick < 83) begin
                kind = FK_TRUNC;
            end else if (pick < 90) begin
                kind = FK_TOO_BIG;
            end else begin
                kind = FK_NOISE;
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            build_frame(kind);
            send_frame();
            if (frame_count == 20 || frame_count == 30) begin
                wait_results_drained();
            end
        end

        // wait for the tail to drain
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DrainTail) @(posedge i_clk);

        $display("covered %0d frames, %0d bytes; %0d payload and %0d status results checked",
                 frame_count, bytes_sent, payload_seen, status_seen);
        $display("status codes seen (bit per code, bad start down to ok): %b", status_mask);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
